### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// sequence must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) not (prop)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)

`endif

`endif

### sv/csalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_pkg
// shared types and constants of the column scalar alu
// ----------------------------------------------------------------------------
package csalu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int OP_WIDTH   = 4;
  localparam int CFG_IDX_W  = 2;

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // divider step counter
  localparam int DIV_CNT_W = $clog2(DATA_WIDTH + 1);

  typedef enum logic [OP_WIDTH-1:0] {
    OP_PREV_DIFF = 4'd0,
    OP_EQ        = 4'd1,
    OP_NEQ       = 4'd2,
    OP_GT        = 4'd3,
    OP_LT        = 4'd4,
    OP_GEQ       = 4'd5,
    OP_LEQ       = 4'd6,
    OP_ADD       = 4'd7,
    OP_SUB       = 4'd8,
    OP_MUL       = 4'd9,
    OP_DIV       = 4'd10,
    OP_REM       = 4'd11
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALAR    = 2'd1;

  // one classified item as it waits for the back end
  typedef struct packed {
    logic [DATA_WIDTH-1:0] element;
    logic                  last;
    logic                  differs;
  } q_entry_t;

endpackage

### sv/csalu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_front
// accepts column items and tags each with its previous-value difference
// ----------------------------------------------------------------------------
module csalu_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [csalu_pkg::DATA_WIDTH-1:0] in_tdata,
  input  logic                             in_tlast,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output csalu_pkg::q_entry_t              q_data_o
);

  logic [csalu_pkg::DATA_WIDTH-1:0] prev_r;
  logic                             have_prev_r;

  assign in_tready = !q_full_i;
  assign q_push_o  = in_tvalid && in_tready;

  always_comb begin
    q_data_o.element = in_tdata;
    q_data_o.last    = in_tlast;
    // first element of a column always counts as different
    q_data_o.differs = !have_prev_r || (prev_r != in_tdata);
  end

  always_ff @(posedge clk) begin
    if (q_push_o) begin
      prev_r <= in_tdata;
    end
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (q_push_o) begin
      have_prev_r <= !in_tlast;
    end
  end

endmodule

### sv/csalu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_queue
// short fifo that decouples the front and back ends
// ----------------------------------------------------------------------------
module csalu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  csalu_pkg::q_entry_t push_data_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output csalu_pkg::q_entry_t head_o
);

  csalu_pkg::q_entry_t              mem_r [csalu_pkg::QDEPTH];
  logic [csalu_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [csalu_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [csalu_pkg::QCNT_W-1:0]     cnt_r;

  assign full_o  = (cnt_r == csalu_pkg::QCNT_W'(csalu_pkg::QDEPTH));
  assign valid_o = (cnt_r != '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### sv/csalu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module csalu_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic [csalu_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [csalu_pkg::DATA_WIDTH-1:0] divisor_i,
  output logic                             busy_o,
  output logic [csalu_pkg::DATA_WIDTH-1:0] quotient_o,
  output logic [csalu_pkg::DATA_WIDTH-1:0] remainder_o
);

  localparam int DW = csalu_pkg::DATA_WIDTH;

  logic [DW-1:0]                      quo_r;
  logic [DW-1:0]                      rem_r;
  logic [DW-1:0]                      dvs_r;
  logic [csalu_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [DW:0]                        rem_sh;
  logic [DW:0]                        trial;

  assign rem_sh      = {rem_r, quo_r[DW-1]};
  assign trial       = rem_sh - {1'b0, dvs_r};
  assign busy_o      = (cnt_r != '0);
  assign quotient_o  = quo_r;
  assign remainder_o = rem_r;

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_o) begin
      // no borrow: the divisor fits, keep the difference
      if (!trial[DW]) begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= csalu_pkg::DIV_CNT_W'(DW);
    end else if (busy_o) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### sv/csalu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_back
// executes queued items against the scalar and holds the result register
// ----------------------------------------------------------------------------
module csalu_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [csalu_pkg::OP_WIDTH-1:0]    op_i,
  input  logic [csalu_pkg::DATA_WIDTH-1:0]  scalar_i,
  input  logic                              q_valid_i,
  input  csalu_pkg::q_entry_t               q_head_i,
  output logic                              q_pop_o,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [csalu_pkg::DATA_WIDTH-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int DW = csalu_pkg::DATA_WIDTH;

  typedef enum logic {
    ST_EXEC,
    ST_DIV
  } state_t;

  state_t        state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic          out_dz_r, out_dz_nxt;
  logic          out_last_r, out_last_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic          pend_rem_r, pend_rem_nxt;

  logic          out_free;
  logic          is_divide;
  logic          div_start;
  logic          div_busy;
  logic [DW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic [DW-1:0] x;
  logic [DW-1:0] alu_res;
  logic          alu_dz;
  logic [2*DW-1:0] product;

  assign x         = q_head_i.element;
  assign out_free  = !out_valid_r || out_tready;
  assign is_divide = ((op_i == csalu_pkg::OP_DIV) || (op_i == csalu_pkg::OP_REM))
                     && (scalar_i != '0);
  assign product   = x * scalar_i;

  // operations worked out without the divider, divide by zero included
  always_comb begin
    alu_res = '0;
    alu_dz  = 1'b0;
    unique case (op_i)
      csalu_pkg::OP_PREV_DIFF: alu_res = DW'(q_head_i.differs);
      csalu_pkg::OP_EQ:        alu_res = DW'(x == scalar_i);
      csalu_pkg::OP_NEQ:       alu_res = DW'(x != scalar_i);
      csalu_pkg::OP_GT:        alu_res = DW'(x > scalar_i);
      csalu_pkg::OP_LT:        alu_res = DW'(x < scalar_i);
      csalu_pkg::OP_GEQ:       alu_res = DW'(x >= scalar_i);
      csalu_pkg::OP_LEQ:       alu_res = DW'(x <= scalar_i);
      csalu_pkg::OP_ADD:       alu_res = x + scalar_i;
      csalu_pkg::OP_SUB:       alu_res = x - scalar_i;
      csalu_pkg::OP_MUL:       alu_res = product[DW-1:0];
      csalu_pkg::OP_DIV: begin
        alu_res = '1;
        alu_dz  = 1'b1;
      end
      csalu_pkg::OP_REM: begin
        alu_res = x;
        alu_dz  = 1'b1;
      end
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_dz_nxt    = out_dz_r;
    out_last_nxt  = out_last_r;
    pend_last_nxt = pend_last_r;
    pend_rem_nxt  = pend_rem_r;
    q_pop_o       = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        if (q_valid_i && is_divide) begin
          q_pop_o       = 1'b1;
          div_start     = 1'b1;
          pend_last_nxt = q_head_i.last;
          pend_rem_nxt  = (op_i == csalu_pkg::OP_REM);
          state_nxt     = ST_DIV;
        end else if (q_valid_i && out_free) begin
          q_pop_o       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = alu_res;
          out_dz_nxt    = alu_dz;
          out_last_nxt  = q_head_i.last;
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_rem_r ? div_rem : div_quo;
          out_dz_nxt    = 1'b0;
          out_last_nxt  = pend_last_r;
          state_nxt     = ST_EXEC;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_dz_r    <= out_dz_nxt;
    out_last_r  <= out_last_nxt;
    pend_last_r <= pend_last_nxt;
    pend_rem_r  <= pend_rem_nxt;
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  csalu_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (div_start),
    .dividend_i  (x),
    .divisor_i   (scalar_i),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dz_r;
  assign out_tlast  = out_last_r;

endmodule

### sv/column_scalar_alu.sv
`timescale 1ns / 1ps
// results of tests, add, sub, mul and /0 pass through the queue and the output register
// div and rem with a nonzero scalar pass through the queue, the divider and the output register
// throughput: 1 item per cycle while the output is not stalled, for operations that skip
//   the divider; div and rem hold the back end until the divider is through: a load,
//   32 radix-2 divider steps of one quotient bit each and a result write
// reset: synchronous active-low rst_n clears config, column tracking, queue, outputs
// ----------------------------------------------------------------------------
// column_scalar_alu
// applies a configured operation between each column element and a scalar
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module column_scalar_alu (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [csalu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csalu_pkg::DATA_WIDTH-1:0]   cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [csalu_pkg::DATA_WIDTH-1:0]   in_tdata,   // [31:0] element
  input  logic                               in_tlast,   // last_in_column
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [csalu_pkg::DATA_WIDTH-1:0]   out_tdata,  // [31:0] result_value
  output logic                               out_tuser,  // [0] divide_by_zero
  output logic                               out_tlast   // last
);

  // configuration registers; the user must write them only while the block is idle, which the block does not enforce
  logic [csalu_pkg::OP_WIDTH-1:0]   op_r;
  logic [csalu_pkg::DATA_WIDTH-1:0] scalar_r;

  // front to queue
  logic                q_push;
  logic                q_full;
  csalu_pkg::q_entry_t q_push_data;

  // queue to back
  logic                q_pop;
  logic                q_valid;
  csalu_pkg::q_entry_t q_head;

  // operation classes and result views for the checks below
  logic                dz_out;
  logic                op_is_div;
  logic                op_divides;
  logic                op_tests;
  logic                res_hi_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= '0;
      scalar_r <= '0;
    end else if (cfg_we) begin
      // writes to indexes beyond the register list are dropped
      case (cfg_index)
        csalu_pkg::CFG_OPERATION: op_r     <= cfg_wdata[csalu_pkg::OP_WIDTH-1:0];
        csalu_pkg::CFG_SCALAR:    scalar_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: takes each transfer and tags it with the prev-diff flag
  csalu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_push_data)
  );

  // two-entry queue lets the front keep taking items during a divide
  csalu_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // back: alu, shared divider and the output register
  csalu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_i       (op_r),
    .scalar_i   (scalar_r),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign dz_out      = out_tvalid && out_tuser;
  assign op_is_div   = (op_r == csalu_pkg::OP_DIV);
  assign op_divides  = op_is_div || (op_r == csalu_pkg::OP_REM);
  assign op_tests    = (op_r <= csalu_pkg::OP_LEQ);
  assign res_hi_zero = (out_tdata[csalu_pkg::DATA_WIDTH-1:1] == '0);

  // divide-by-zero flag only comes out of div or rem
  `ASSERT_AT(a_dz_only_div, clk, rst_n, dz_out |-> op_divides, "divide_by_zero outside div/rem")

  // test operations give a single bit
  `ASSERT_AT(a_test_is_bool, clk, rst_n, out_tvalid && op_tests |-> res_hi_zero, "test not 0/1")

  // div by zero returns all ones
  `ASSERT_AT(a_div_zero_ones, clk, rst_n, dz_out && op_is_div |-> (&out_tdata), "div /0 not ones")

  // never pop an empty queue
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, (q_pop && !q_valid), "queue popped while empty")

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives column streams through column_scalar_alu and checks every result
// transfer against an in-bench model of the operation, the scalar and the
// column tracking, with random idling on both stream sides
// ----------------------------------------------------------------------------
module tb;

  localparam int DW   = csalu_pkg::DATA_WIDTH;
  localparam int OPW  = csalu_pkg::OP_WIDTH;
  localparam int IDXW = csalu_pkg::CFG_IDX_W;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 24;
  // quiet cycles allowed with no transfer and no register write
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 600;
  localparam int BURST_ITEMS  = 150;

  localparam logic [DW-1:0] ALL_ONES = '1;
  localparam logic [DW-1:0] MID_SCALAR = {1'b1, {(DW-1){1'b0}}};

  // register indexes that the block has no register behind
  localparam logic [IDXW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [IDXW-1:0] CFG_SPARE_HI = 2'd3;

  // operation codes with no operation behind them
  localparam logic [OPW-1:0] OP_UNUSED_FIRST = 4'd12;
  localparam logic [OPW-1:0] OP_UNUSED_LAST  = 4'd15;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          div_zero;
    logic          last;
  } alu_result_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            cfg_we     = 1'b0;
  logic [IDXW-1:0] cfg_index  = '0;
  logic [DW-1:0]   cfg_wdata  = '0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [DW-1:0]   in_tdata   = '0;   // [31:0] element
  logic            in_tlast   = 1'b0; // last_in_column
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [DW-1:0]   out_tdata;         // [31:0] result_value
  logic            out_tuser;         // [0] divide_by_zero
  logic            out_tlast;         // last

  // model copy of the registers and the column tracking
  logic [OPW-1:0]  op_model        = csalu_pkg::OP_PREV_DIFF;
  logic [DW-1:0]   scalar_model    = '0;
  logic [DW-1:0]   prev_model      = '0;
  logic            have_prev_model = 1'b0;

  alu_result_t     pending_results[$];
  logic [DW-1:0]   last_sent  = '0;
  bit              idle_on    = 1'b1;
  int              mismatches = 0;
  int              quiet_cycles = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  column_scalar_alu u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // expected result of one element; also advances the column tracking
  function automatic alu_result_t predict_alu(input logic [DW-1:0] x,
                                              input logic lastf);
    alu_result_t r;
    logic [DW-1:0] s;
    r = '0;
    s = scalar_model;
    r.last = lastf;
    case (op_model)
      csalu_pkg::OP_PREV_DIFF: r.value = DW'(!have_prev_model || prev_model != x);
      csalu_pkg::OP_EQ:        r.value = DW'(x == s);
      csalu_pkg::OP_NEQ:       r.value = DW'(x != s);
      csalu_pkg::OP_GT:        r.value = DW'(x > s);
      csalu_pkg::OP_LT:        r.value = DW'(x < s);
      csalu_pkg::OP_GEQ:       r.value = DW'(x >= s);
      csalu_pkg::OP_LEQ:       r.value = DW'(x <= s);
      csalu_pkg::OP_ADD:       r.value = x + s;
      csalu_pkg::OP_SUB:       r.value = x - s;
      csalu_pkg::OP_MUL:       r.value = x * s;
      csalu_pkg::OP_DIV: begin
        if (s == '0) begin
          r.value    = ALL_ONES;
          r.div_zero = 1'b1;
        end else begin
          r.value = x / s;
        end
      end
      csalu_pkg::OP_REM: begin
        if (s == '0) begin
          r.value    = x;
          r.div_zero = 1'b1;
        end else begin
          r.value = x % s;
        end
      end
      default: r.value = '0;
    endcase
    // tracking runs whatever the operation
    prev_model      = x;
    have_prev_model = !lastf;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // result check first, then prediction of the input transfer at the same edge
  always @(posedge clk) begin : scoreboard
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value)
          report_mismatch($sformatf("value %h, expected %h", out_tdata, want.value));
        if (out_tuser !== want.div_zero)
          report_mismatch($sformatf("divide_by_zero %b, expected %b", out_tuser,
                                    want.div_zero));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
      end
    end
    if (rst_n && in_tvalid && in_tready)
      pending_results.push_back(predict_alu(in_tdata, in_tlast));
  end

  // receiver side back-pressure
  always @(posedge clk) begin
    if (idle_on) begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ends a hung run: counts edges with no transfer and no register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("** column_scalar_alu: FAILED **");
      $finish;
    end
  end

  // one register write; called only while no item is in flight
  task automatic write_cfg(input logic [IDXW-1:0] idx,
                           input logic [DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == csalu_pkg::CFG_OPERATION) begin
      op_model = data[OPW-1:0];
    end else if (idx == csalu_pkg::CFG_SCALAR) begin
      scalar_model = data;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // operation write with random bits above the code field
  task automatic write_op(input logic [OPW-1:0] op);
    logic [DW-1:0] w;
    w = $urandom();
    w[OPW-1:0] = op;
    write_cfg(csalu_pkg::CFG_OPERATION, w);
  endtask

  // offers one element and holds it until the input transfer
  task automatic send_element(input logic [DW-1:0] elem, input logic lastf);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= elem;
    in_tlast  <= lastf;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_sent = elem;
  endtask

  // stops the input side and waits for every expected result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one random setting followed by a run of columns under it
  task automatic run_random_phase(input int n_items);
    logic [DW-1:0]   s;
    logic [DW-1:0]   e;
    logic [OPW-1:0]  op;
    logic [IDXW-1:0] spare;
    if ($urandom_range(99) < 8) begin
      op = OPW'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    end else begin
      op = OPW'($urandom_range(csalu_pkg::OP_REM, csalu_pkg::OP_PREV_DIFF));
    end
    case ($urandom_range(5))
      0:       s = '0;
      1:       s = 1;
      2:       s = ALL_ONES;
      3:       s = $urandom_range(255, 1);
      default: s = $urandom();
    endcase
    if ($urandom_range(3) == 0) begin
      spare = IDXW'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO));
      write_cfg(spare, $urandom());
    end
    if ($urandom_range(1)) begin
      write_cfg(csalu_pkg::CFG_SCALAR, s);
      write_op(op);
    end else begin
      write_op(op);
      write_cfg(csalu_pkg::CFG_SCALAR, s);
    end
    for (int i = 0; i < n_items; i++) begin
      // near-scalar values and repeats reach the comparison and prev-diff edges
      case ($urandom_range(9))
        0:       e = '0;
        1:       e = ALL_ONES;
        2:       e = s;
        3:       e = s + 1;
        4:       e = s - 1;
        5, 6:    e = last_sent;
        7:       e = $urandom_range(65535);
        default: e = $urandom();
      endcase
      send_element(e, $urandom_range(5) == 0);
    end
    drain_results();
  endtask

  // defaults after reset: prev-diff against an empty column
  task automatic test_reset_state();
    send_element(ALL_ONES, 1'b0);
    send_element(ALL_ONES, 1'b0);
    send_element('0, 1'b1);
    send_element('0, 1'b0);   // first of a new column differs
    send_element('0, 1'b1);
    drain_results();
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_ignored_index();
    write_cfg(CFG_SPARE_LO, ALL_ONES);
    write_cfg(CFG_SPARE_HI, ALL_ONES);
    send_element('0, 1'b1);
    drain_results();
  endtask

  // each comparison at equality and at one end of the range: all ones for odd codes, zero for even
  task automatic test_compare_ops();
    write_cfg(csalu_pkg::CFG_SCALAR, MID_SCALAR);
    for (int k = csalu_pkg::OP_EQ; k <= csalu_pkg::OP_LEQ; k++) begin
      write_op(OPW'(k));
      send_element(MID_SCALAR, 1'b0);
      send_element((k % 2) ? ALL_ONES : '0, 1'b1);
      drain_results();
    end
  endtask

  // wrap-around arithmetic, division by zero and an unused code
  task automatic test_arith_ops();
    write_cfg(csalu_pkg::CFG_SCALAR, ALL_ONES);
    for (int k = csalu_pkg::OP_ADD; k <= csalu_pkg::OP_REM; k++) begin
      write_op(OPW'(k));
      send_element((k == csalu_pkg::OP_SUB) ? '0 :
                   ((k == csalu_pkg::OP_REM) ? ALL_ONES - 1 : ALL_ONES),
                   k == csalu_pkg::OP_REM);
      drain_results();
    end
    write_cfg(csalu_pkg::CFG_SCALAR, '0);
    write_op(csalu_pkg::OP_DIV);
    send_element(ALL_ONES, 1'b0);
    drain_results();
    write_op(csalu_pkg::OP_REM);
    send_element(ALL_ONES, 1'b1);
    drain_results();
    // all-ones write lands on the highest unused code
    write_cfg(csalu_pkg::CFG_OPERATION, ALL_ONES);
    send_element(ALL_ONES, 1'b0);
    drain_results();
  endtask

  task automatic test_random_columns(input int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      run_random_phase($urandom_range(60, 10));
      sent += 1;
    end
  endtask

  // back-to-back transfers on both sides, no idling at all
  task automatic test_back_to_back();
    int sent;
    int n;
    sent = 0;
    idle_on = 1'b0;
    while (sent < BURST_ITEMS) begin
      n = $urandom_range(50, 20);
      run_random_phase(n);
      sent += n;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_ignored_index();
    test_compare_ops();
    test_arith_ops();
    // phase count rather than item count: about 35 items a phase
    test_random_columns(RANDOM_ITEMS / 35);
    test_back_to_back();
    test_random_columns(RANDOM_ITEMS / 35);

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** column_scalar_alu: PASSED **");
    end else begin
      $display("** column_scalar_alu: FAILED **");
    end
    $finish;
  end

endmodule
